// ----- src/pip_pkg.sv -----
// ============================================================================
// pip_pkg
// Shared widths, types and edge setup for the point-in-polygon test.
// ============================================================================
package pip_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int S_TDATA_W   = ((4 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

    typedef struct packed {
        logic  en;
        logic  span_pos;
        diff_t a0;
        diff_t a1;
        diff_t b0;
        diff_t b1;
    } edge_ops_t;

    typedef struct packed {
        edge_ops_t ea;
        edge_ops_t eb;
        logic      first;
        logic      last;
    } q_item_t;

    typedef struct packed {
        logic  en;
        logic  span_pos;
        prod_t lhs;
        prod_t rhs;
    } edge_prod_t;

    function automatic edge_ops_t edge_prep(
        input coord_t xi,
        input coord_t yi,
        input coord_t xj,
        input coord_t yj,
        input coord_t qx,
        input coord_t qy,
        input logic   valid
    );
        edge_ops_t e;
        logic      straddle;
        logic      left;
        straddle   = (yi < qy) != (yj < qy);
        left       = (xi <= qx) || (xj <= qx);
        e.en       = valid && straddle && left;
        e.span_pos = (yj > yi);
        e.a0       = diff_t'(qy) - diff_t'(yi);
        e.a1       = diff_t'(xj) - diff_t'(xi);
        e.b0       = diff_t'(qx) - diff_t'(xi);
        e.b1       = diff_t'(yj) - diff_t'(yi);
        return e;
    endfunction

endpackage

// ----- src/point_in_polygon_test.sv -----
// The last vertex's result passes through the queue, the product registers and
// the output register. Throughput: one vertex per cycle while the queue is not
// full; each vertex uses one edge unit, and the closing edge on a last vertex
// uses the second unit in the same stage. Reset (rst_n low, asynchronous):
// polygon state, queue and output valid cleared; the next vertex starts a new polygon.
// ============================================================================
// point_in_polygon_test
// Crossing-number point-in-polygon test over a streamed vertex list.
// ============================================================================
module point_in_polygon_test
    import pip_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // query_x, query_y, vertex_x, vertex_y
    input  logic                 s_axis_tlast,   // last_vertex
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // [0] inside_res
);

    logic    push;
    logic    can_push;
    q_item_t push_item;
    logic    pop;
    logic    can_pop;
    q_item_t pop_item;

    assign s_axis_tready = can_push;

    pip_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (can_push),
        .query_x     (coord_t'(s_axis_tdata[COORD_WIDTH-1:0])),
        .query_y     (coord_t'(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .vertex_x    (coord_t'(s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
        .vertex_y    (coord_t'(s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH])),
        .last_vertex (s_axis_tlast),
        .push        (push),
        .item        (push_item)
    );

    pip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .can_push  (can_push),
        .pop       (pop),
        .can_pop   (can_pop),
        .pop_item  (pop_item)
    );

    pip_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (can_pop),
        .q_item        (pop_item),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- src/pip_front.sv -----
// ============================================================================
// pip_front
// Accepts vertices, tracks polygon state and prepares both edge tests.
// ============================================================================
module pip_front
    import pip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_ready,
    input  coord_t  query_x,
    input  coord_t  query_y,
    input  coord_t  vertex_x,
    input  coord_t  vertex_y,
    input  logic    last_vertex,
    output logic    push,
    output q_item_t item
);

    coord_t held_qx_reg, held_qx_next;
    coord_t held_qy_reg, held_qy_next;
    coord_t first_x_reg, first_x_next;
    coord_t first_y_reg, first_y_next;
    coord_t prev_x_reg, prev_x_next;
    coord_t prev_y_reg, prev_y_next;
    logic   within_reg, within_next;

    coord_t qx_use;
    coord_t qy_use;
    coord_t fx_use;
    coord_t fy_use;

    assign push   = in_valid && in_ready;
    assign qx_use = within_reg ? held_qx_reg : query_x;
    assign qy_use = within_reg ? held_qy_reg : query_y;
    assign fx_use = within_reg ? first_x_reg : vertex_x;
    assign fy_use = within_reg ? first_y_reg : vertex_y;

    always_comb
    begin
        item.ea    = edge_prep(vertex_x, vertex_y, prev_x_reg, prev_y_reg,
                               qx_use, qy_use, within_reg);
        item.eb    = edge_prep(fx_use, fy_use, vertex_x, vertex_y,
                               qx_use, qy_use, last_vertex);
        item.first = !within_reg;
        item.last  = last_vertex;
    end

    always_comb
    begin
        held_qx_next = held_qx_reg;
        held_qy_next = held_qy_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        within_next  = within_reg;
        if (push)
        begin
            held_qx_next = qx_use;
            held_qy_next = qy_use;
            first_x_next = fx_use;
            first_y_next = fy_use;
            prev_x_next  = vertex_x;
            prev_y_next  = vertex_y;
            within_next  = !last_vertex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_qx_reg <= '0;
            held_qy_reg <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            within_reg  <= 1'b0;
        end
        else
        begin
            held_qx_reg <= held_qx_next;
            held_qy_reg <= held_qy_next;
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            within_reg  <= within_next;
        end
    end

endmodule

// ----- src/pip_queue.sv -----
// ============================================================================
// pip_queue
// Short queue of prepared edge tests between front and back.
// ============================================================================
module pip_queue
    import pip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    output logic    can_push,
    input  logic    pop,
    output logic    can_pop,
    output q_item_t pop_item
);

    q_item_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign can_push = (count_reg != QCNT_W'(QDEPTH));
    assign can_pop  = (count_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];
    assign do_push  = push && can_push;
    assign do_pop   = pop && can_pop;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/pip_back.sv -----
// ============================================================================
// pip_back
// Multiplies, compares, tracks crossing parity and holds the result.
// ============================================================================
module pip_back
    import pip_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  q_item_t              q_item,
    output logic                 q_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // [0] inside_res
);

    logic       mul_valid_reg, mul_valid_next;
    edge_prod_t pa_reg;
    edge_prod_t pb_reg;
    logic       mfirst_reg;
    logic       mlast_reg;
    logic       parity_reg, parity_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_data_reg, out_data_next;

    logic       out_free;
    logic       mul_adv;
    logic       mul_ready;
    logic       cross_a;
    logic       cross_b;

    function automatic edge_prod_t edge_mul(input edge_ops_t e);
        edge_prod_t p;
        p.en       = e.en;
        p.span_pos = e.span_pos;
        p.lhs      = prod_t'($signed(e.a0)) * prod_t'($signed(e.a1));
        p.rhs      = prod_t'($signed(e.b0)) * prod_t'($signed(e.b1));
        return p;
    endfunction

    function automatic logic edge_cross(input edge_prod_t p);
        logic lt;
        lt = p.span_pos ? ($signed(p.lhs) < $signed(p.rhs))
                        : ($signed(p.rhs) < $signed(p.lhs));
        return p.en && lt;
    endfunction

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign mul_adv   = mul_valid_reg && (!mlast_reg || out_free);
    assign mul_ready = !mul_valid_reg || mul_adv;
    assign q_pop     = q_valid && mul_ready;
    assign cross_a   = edge_cross(pa_reg);
    assign cross_b   = edge_cross(pb_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, out_data_reg};

    always_comb
    begin
        mul_valid_next = mul_valid_reg;
        parity_next    = parity_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (mul_adv)
        begin
            mul_valid_next = 1'b0;
            parity_next    = (mfirst_reg ? 1'b0 : parity_reg) ^ cross_a ^ cross_b;
            if (mlast_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = parity_next;
            end
        end
        if (q_pop)
        begin
            mul_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pa_reg     <= edge_mul(q_item.ea);
            pb_reg     <= edge_mul(q_item.eb);
            mfirst_reg <= q_item.first;
            mlast_reg  <= q_item.last;
        end
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
